[sv/vtyp_pkg.sv]
// ----------------------------------------------------------------------------
// vtyp_pkg
// Shared constants, arctangent table and sideband types for the yaw/pitch
// CORDIC pipeline.
// ----------------------------------------------------------------------------
package vtyp_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ANGLE_FRAC_DEF   = 8;
  localparam int unsigned ATAN_TABLE_LEN   = 24;

  // datapath widths: scaled vector with CORDIC gain, angle accumulator
  localparam int unsigned DATA_W   = 28;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned ACC_FRAC = 20;
  localparam int unsigned WRAP_W   = ACC_FRAC + 9;

  localparam logic [20:0]             GAIN_Q20  = 21'd1726753;
  localparam logic signed [ACC_W-1:0] HALF_TURN = 32'sd188743680;
  localparam logic signed [ACC_W-1:0] FULL_TURN = 32'sd377487360;

  typedef enum logic [2:0] {
    YAW_CORDIC,
    YAW_ZERO,
    YAW_90,
    YAW_180,
    YAW_270
  } yaw_sel_e;

  typedef enum logic [1:0] {
    PITCH_CORDIC,
    PITCH_ZERO,
    PITCH_90,
    PITCH_270
  } pitch_sel_e;

  typedef struct packed {
    yaw_sel_e                  yaw_sel;
    pitch_sel_e                pitch_sel;
    logic signed [DATA_W-1:0]  pz;
  } yaw_side_t;

  typedef struct packed {
    yaw_sel_e                  yaw_sel;
    pitch_sel_e                pitch_sel;
    logic signed [ACC_W-1:0]   yaw_acc;
  } pitch_side_t;

  // atan(2^-i) in degrees, Q20, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_q20(input int unsigned idx);
    logic signed [ACC_W-1:0] val;
    case (idx)
      0:       val = 32'sd47185920;
      1:       val = 32'sd27855475;
      2:       val = 32'sd14718068;
      3:       val = 32'sd7471121;
      4:       val = 32'sd3750058;
      5:       val = 32'sd1876857;
      6:       val = 32'sd938658;
      7:       val = 32'sd469358;
      8:       val = 32'sd234682;
      9:       val = 32'sd117342;
      10:      val = 32'sd58671;
      11:      val = 32'sd29335;
      12:      val = 32'sd14668;
      13:      val = 32'sd7334;
      14:      val = 32'sd3667;
      15:      val = 32'sd1833;
      16:      val = 32'sd917;
      17:      val = 32'sd458;
      18:      val = 32'sd229;
      19:      val = 32'sd115;
      20:      val = 32'sd57;
      21:      val = 32'sd29;
      22:      val = 32'sd14;
      23:      val = 32'sd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[sv/vtyp_cordic.sv]
// ----------------------------------------------------------------------------
// vtyp_cordic
// Unrolled vectoring CORDIC, one micro-rotation per register stage. Drives y
// towards zero, returns the magnitude (with gain) and the angle turned.
// ----------------------------------------------------------------------------
module vtyp_cordic #(
  parameter int unsigned STEPS  = vtyp_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [vtyp_pkg::DATA_W-1:0]  x_i,
  input  logic signed [vtyp_pkg::DATA_W-1:0]  y_i,
  input  logic signed [vtyp_pkg::ACC_W-1:0]   acc_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic signed [vtyp_pkg::DATA_W-1:0]  x_o,
  output logic signed [vtyp_pkg::ACC_W-1:0]   acc_o,
  output logic [SIDE_W-1:0]                   side_o
);
  import vtyp_pkg::*;

  logic                     valid_q [STEPS];
  logic signed [DATA_W-1:0] x_q     [STEPS];
  logic signed [DATA_W-1:0] y_q     [STEPS-1];
  logic signed [ACC_W-1:0]  acc_q   [STEPS];
  logic [SIDE_W-1:0]        side_q  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                     valid_in;
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] y_in;
    logic signed [ACC_W-1:0]  acc_in;
    logic [SIDE_W-1:0]        side_in;
    logic signed [DATA_W-1:0] x_d;
    logic signed [ACC_W-1:0]  acc_d;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign x_in     = x_i;
      assign y_in     = y_i;
      assign acc_in   = acc_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign x_in     = x_q[i-1];
      assign y_in     = y_q[i-1];
      assign acc_in   = acc_q[i-1];
      assign side_in  = side_q[i-1];
    end

    always_comb begin
      if (!y_in[DATA_W-1]) begin
        x_d   = x_in + (y_in >>> i);
        acc_d = acc_in + atan_q20(i);
      end else begin
        x_d   = x_in - (y_in >>> i);
        acc_d = acc_in - atan_q20(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i]    <= x_d;
      acc_q[i]  <= acc_d;
      side_q[i] <= side_in;
    end

    // the last stage only needs x and the angle
    if (i < STEPS - 1) begin : g_y
      logic signed [DATA_W-1:0] y_d;

      always_comb begin
        if (!y_in[DATA_W-1]) begin
          y_d = y_in - (x_in >>> i);
        end else begin
          y_d = y_in + (x_in >>> i);
        end
      end

      always_ff @(posedge clk_i) begin
        y_q[i] <= y_d;
      end
    end
  end

  assign valid_o = valid_q[STEPS-1];
  assign x_o     = x_q[STEPS-1];
  assign acc_o   = acc_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

[sv/vector_to_yaw_pitch_core.sv]
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_core
// Yaw and negated pitch of a signed 3-D direction vector, in degrees.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low; busy
// is held low, so a new vector may enter on every cycle (one per cycle).
// vec_x_i, vec_y_i, vec_z_i are signed 16-bit components.
// Each result is shown for one cycle with done_o high: yaw_angle_o in
// [0, 360) and pitch_angle_o in (-360, 0], both scaled by 2^ANGLE_FRAC_BITS.
// The strobe rises once the accepted vector has passed, in order: input
// register, pre-rotation and gain multiply, the yaw CORDIC stages, the
// pitch CORDIC stages that follow on the yaw magnitude, then angle wrap and
// rounding. Results leave in accept order.
// Reset empties the pipeline; nothing in flight is delivered. The receiver
// has no hold-off, so results are never stalled.
// ----------------------------------------------------------------------------
module vector_to_yaw_pitch_core #(
  parameter int unsigned CORDIC_STEPS    = vtyp_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = vtyp_pkg::ANGLE_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic               done_o,
  output logic [16:0]        yaw_angle_o,
  output logic signed [17:0] pitch_angle_o
);
  import vtyp_pkg::*;

  localparam int unsigned STEPS_EFF = (CORDIC_STEPS > ATAN_TABLE_LEN) ?
                                      ATAN_TABLE_LEN : CORDIC_STEPS;
  localparam int unsigned LATENCY   = 2 * STEPS_EFF + 4;
  localparam int unsigned RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned RND_W     = ANGLE_FRAC_BITS + 10;
  localparam int unsigned EXT_W     = RND_W + 18;

  localparam logic [RND_W-1:0]  ANG_90   = RND_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [RND_W-1:0]  ANG_180  = RND_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [RND_W-1:0]  ANG_270  = RND_W'(270 << ANGLE_FRAC_BITS);
  localparam logic [RND_W-1:0]  ANG_360  = RND_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [WRAP_W:0]   RND_HALF = (WRAP_W + 1)'(1 << (RND_SHIFT - 1));
  localparam int unsigned       SIDE_YAW_W   = $bits(yaw_side_t);
  localparam int unsigned       SIDE_PITCH_W = $bits(pitch_side_t);

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---- stage A: input register ----
  logic               a_valid_q;
  logic signed [15:0] a_x_q;
  logic signed [15:0] a_y_q;
  logic signed [15:0] a_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q <= vec_x_i;
      a_y_q <= vec_y_i;
      a_z_q <= vec_z_i;
    end
  end

  // ---- stage B: pre-rotation, gain multiply, special cases ----
  logic                     x_zero, y_zero, z_zero;
  logic signed [DATA_W-1:0] cx_ext, cy_ext;
  logic signed [37:0]       pz_prod;
  logic signed [DATA_W-1:0] b_x_d, b_y_d;
  logic signed [ACC_W-1:0]  b_acc_d;
  yaw_side_t                b_side_d;

  logic                     b_valid_q;
  logic signed [DATA_W-1:0] b_x_q, b_y_q;
  logic signed [ACC_W-1:0]  b_acc_q;
  yaw_side_t                b_side_q;

  assign x_zero  = (a_x_q == '0);
  assign y_zero  = (a_y_q == '0);
  assign z_zero  = (a_z_q == '0);
  assign cx_ext  = {{(DATA_W-24){a_x_q[15]}}, a_x_q, 8'h00};
  assign cy_ext  = {{(DATA_W-24){a_y_q[15]}}, a_y_q, 8'h00};
  assign pz_prod = a_z_q * $signed({1'b0, GAIN_Q20});

  always_comb begin
    if (a_x_q[15]) begin
      b_x_d   = -cx_ext;
      b_y_d   = -cy_ext;
      b_acc_d = HALF_TURN;
    end else begin
      b_x_d   = cx_ext;
      b_y_d   = cy_ext;
      b_acc_d = '0;
    end

    // z * 256 * gain / 2^20, floor
    b_side_d.pz = {{(DATA_W-26){pz_prod[37]}}, pz_prod[37:12]};

    if (x_zero && y_zero) begin
      b_side_d.yaw_sel   = YAW_ZERO;
      b_side_d.pitch_sel = (!a_z_q[15] && !z_zero) ? PITCH_90 : PITCH_270;
    end else begin
      if (x_zero) begin
        b_side_d.yaw_sel = a_y_q[15] ? YAW_270 : YAW_90;
      end else if (y_zero) begin
        b_side_d.yaw_sel = a_x_q[15] ? YAW_180 : YAW_ZERO;
      end else begin
        b_side_d.yaw_sel = YAW_CORDIC;
      end
      b_side_d.pitch_sel = z_zero ? PITCH_ZERO : PITCH_CORDIC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_x_q    <= b_x_d;
    b_y_q    <= b_y_d;
    b_acc_q  <= b_acc_d;
    b_side_q <= b_side_d;
  end

  // ---- yaw CORDIC ----
  logic                     yc_valid;
  logic signed [DATA_W-1:0] yc_radius;
  logic signed [ACC_W-1:0]  yc_acc;
  logic [SIDE_YAW_W-1:0]    yc_side_vec;
  yaw_side_t                yc_side;
  pitch_side_t              pc_side_in;

  vtyp_cordic #(
    .STEPS  (STEPS_EFF),
    .SIDE_W (SIDE_YAW_W)
  ) u_yaw_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .x_i     (b_x_q),
    .y_i     (b_y_q),
    .acc_i   (b_acc_q),
    .side_i  (b_side_q),
    .valid_o (yc_valid),
    .x_o     (yc_radius),
    .acc_o   (yc_acc),
    .side_o  (yc_side_vec)
  );

  assign yc_side              = yaw_side_t'(yc_side_vec);
  assign pc_side_in.yaw_sel   = yc_side.yaw_sel;
  assign pc_side_in.pitch_sel = yc_side.pitch_sel;
  assign pc_side_in.yaw_acc   = yc_acc;

  // ---- pitch CORDIC on (horizontal length, scaled z) ----
  logic                     pc_valid;
  logic signed [DATA_W-1:0] pc_radius;
  logic signed [ACC_W-1:0]  pc_acc;
  logic [SIDE_PITCH_W-1:0]  pc_side_vec;
  pitch_side_t              pc_side;

  vtyp_cordic #(
    .STEPS  (STEPS_EFF),
    .SIDE_W (SIDE_PITCH_W)
  ) u_pitch_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (yc_valid),
    .x_i     (yc_radius),
    .y_i     (yc_side.pz),
    .acc_i   ('0),
    .side_i  (pc_side_in),
    .valid_o (pc_valid),
    .x_o     (pc_radius),
    .acc_o   (pc_acc),
    .side_o  (pc_side_vec)
  );

  assign pc_side = pitch_side_t'(pc_side_vec);

  // ---- stage D: wrap into one turn ----
  logic signed [ACC_W-1:0] yaw_wr, pitch_wr;
  logic                    d_valid_q;
  logic [WRAP_W-1:0]       d_yaw_q, d_pitch_q;
  logic [WRAP_W-1:0]       d_yaw_d, d_pitch_d;
  yaw_sel_e                d_yaw_sel_q;
  pitch_sel_e              d_pitch_sel_q;

  assign yaw_wr    = pc_side.yaw_acc[ACC_W-1] ? pc_side.yaw_acc + FULL_TURN
                                              : pc_side.yaw_acc;
  assign pitch_wr  = pc_acc[ACC_W-1] ? pc_acc + FULL_TURN : pc_acc;
  assign d_yaw_d   = yaw_wr[WRAP_W-1:0];
  assign d_pitch_d = pitch_wr[WRAP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= pc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d_yaw_q       <= d_yaw_d;
    d_pitch_q     <= d_pitch_d;
    d_yaw_sel_q   <= pc_side.yaw_sel;
    d_pitch_sel_q <= pc_side.pitch_sel;
  end

  // ---- stage E: round half up, fold 360 to 0, special cases ----
  logic [WRAP_W:0]        yaw_sum, pitch_sum;
  logic [RND_W-1:0]       yaw_rnd, pitch_rnd;
  logic [RND_W-1:0]       yaw_val, pitch_val;
  logic [EXT_W-1:0]       yaw_ext, pitch_ext;
  logic                   e_valid_q;
  logic [16:0]            e_yaw_q, e_yaw_d;
  logic signed [17:0]     e_pitch_q, e_pitch_d;

  assign yaw_sum   = {1'b0, d_yaw_q} + RND_HALF;
  assign pitch_sum = {1'b0, d_pitch_q} + RND_HALF;
  assign yaw_rnd   = yaw_sum[WRAP_W:RND_SHIFT];
  assign pitch_rnd = pitch_sum[WRAP_W:RND_SHIFT];

  always_comb begin
    case (d_yaw_sel_q)
      YAW_CORDIC: yaw_val = (yaw_rnd >= ANG_360) ? '0 : yaw_rnd;
      YAW_ZERO:   yaw_val = '0;
      YAW_90:     yaw_val = ANG_90;
      YAW_180:    yaw_val = ANG_180;
      YAW_270:    yaw_val = ANG_270;
      default:    yaw_val = '0;
    endcase

    case (d_pitch_sel_q)
      PITCH_CORDIC: pitch_val = (pitch_rnd >= ANG_360) ? '0 : pitch_rnd;
      PITCH_ZERO:   pitch_val = '0;
      PITCH_90:     pitch_val = ANG_90;
      PITCH_270:    pitch_val = ANG_270;
      default:      pitch_val = '0;
    endcase
  end

  assign yaw_ext   = EXT_W'(yaw_val);
  assign pitch_ext = EXT_W'(pitch_val);
  assign e_yaw_d   = yaw_ext[16:0];
  assign e_pitch_d = 18'd0 - pitch_ext[17:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_yaw_q   <= e_yaw_d;
    e_pitch_q <= e_pitch_d;
  end

  assign done_o        = e_valid_q;
  assign yaw_angle_o   = e_yaw_q;
  assign pitch_angle_o = e_pitch_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transaction");

  a_yaw_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yc_valid |-> !yc_radius[DATA_W-1])
    else $error("yaw CORDIC magnitude overflowed");

  a_pitch_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_valid |-> !pc_radius[DATA_W-1])
    else $error("pitch CORDIC magnitude overflowed");

  a_yaw_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> (ACC_W'(d_yaw_q) < FULL_TURN))
    else $error("yaw not wrapped into one turn");

  a_pitch_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> (ACC_W'(d_pitch_q) < FULL_TURN))
    else $error("pitch not wrapped into one turn");
`endif

endmodule
